### hdl/dnsx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnsx_pkg
// Shared types and constants for the DNS answer address extractor.
// ----------------------------------------------------------------------------
package dnsx_pkg;

   localparam logic [7:0]  PTR_MASK  = 8'hC0;
   localparam int unsigned HDR_LEN   = 12;
   localparam logic [3:0]  FIXED_LEN = 4'd10;
   localparam logic [3:0]  QFIX_LEN  = 4'd4;
   localparam logic [15:0] TYPE_A    = 16'd1;
   localparam logic [15:0] TYPE_AAAA = 16'd28;
   localparam logic [15:0] LEN_A     = 16'd4;
   localparam logic [15:0] LEN_AAAA  = 16'd16;

   // one byte plus the facts the back end needs about it
   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic [15:0] tag;
      logic        first;   // first byte of a packet
   } byte_item_type;

   typedef struct packed {
      logic        is_ipv6;
      logic [63:0] address_high;
      logic [63:0] address_low;
      logic        first_a;
      logic [15:0] result_tag;
   } result_type;

endpackage : dnsx_pkg
`default_nettype wire

### hdl/dnsx_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnsx_front
// Input stage: accepts bytes, tracks the packet's first byte, pushes them on
// into a two-entry queue.
// ----------------------------------------------------------------------------
module dnsx_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire logic [7:0]              in_data,
   input  wire logic                    in_last,
   input  wire logic [15:0]             in_tag,
   output logic                         q_valid,
   input  wire logic                    q_ready,
   output dnsx_pkg::byte_item_type      q_item
);
   import dnsx_pkg::*;

   byte_item_type slot_ff [2];
   byte_item_type slot_in;
   logic          wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          start_ff, start_in;
   logic          push, pop;

   assign in_ready = (count_ff != 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = slot_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_comb begin
      slot_in   = '{data: in_data, last: in_last, tag: in_tag, first: start_ff};
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      start_in  = push ? in_last : start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         start_ff  <= 1'b1;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         start_ff  <= start_in;
      end
      if (push) slot_ff[wr_ptr_ff] <= slot_in;
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("queue overfilled");
   a_full_block: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !in_ready) else $error("accept while full");
   a_first_after_last: assert property (@(posedge clock) disable iff (reset)
      $past(push && in_last) |-> start_ff) else $error("packet start lost");

endmodule : dnsx_front
`default_nettype wire

### hdl/dnsx_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnsx_back
// Parser: walks header, questions and answers one byte a cycle while no stalled
// result holds it, and builds the address results into an output register.
// ----------------------------------------------------------------------------
module dnsx_back #(
   parameter int LENGTH_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    q_valid,
   output logic                         q_ready,
   input  wire dnsx_pkg::byte_item_type q_item,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output dnsx_pkg::result_type         out_result
);
   import dnsx_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER, PH_QNAME, PH_QFIXED, PH_ANAME, PH_AFIXED, PH_RDATA, PH_DONE
   } phase_type;

   localparam logic [LENGTH_BITS-1:0] OFF_MAX = '1;

   phase_type               phase_ff, phase_in;
   logic [LENGTH_BITS-1:0]  offset_ff, offset_in;
   logic [15:0]             qcount_ff, qcount_in, acount_ff, acount_in;
   logic [15:0]             skip_ff, skip_in, rtype_ff, rtype_in, rlen_ff, rlen_in;
   logic [127:0]            addr_ff, addr_in;
   logic                    seen_ff, seen_in;
   logic [15:0]             tag_ff, tag_in;
   logic                    out_valid_ff, out_valid_in;
   result_type              out_ff, out_in;
   logic                    take;
   logic [7:0]              b;
   logic [15:0]             k, acount_dec;
   logic                    is_a, is_6;

   assign q_ready    = !out_valid_ff || out_ready;
   assign take       = q_valid && q_ready;
   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;
   assign b          = q_item.data;

   always_comb begin
      phase_in     = phase_ff;
      offset_in    = offset_ff;
      qcount_in    = qcount_ff;
      acount_in    = acount_ff;
      skip_in      = skip_ff;
      rtype_in     = rtype_ff;
      rlen_in      = rlen_ff;
      addr_in      = addr_ff;
      seen_in      = seen_ff;
      tag_in       = q_item.first ? q_item.tag : tag_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_in       = out_ff;
      k            = {12'd0, FIXED_LEN} - skip_ff;
      acount_dec   = acount_ff - 16'd1;
      is_a         = (rtype_ff == TYPE_A) && (rlen_ff == LEN_A);
      is_6         = (rtype_ff == TYPE_AAAA) && (rlen_ff == LEN_AAAA);
      if (offset_ff != OFF_MAX) offset_in = offset_ff + 1'b1;

      case (phase_ff)
         PH_HEADER: begin
            if (offset_ff == LENGTH_BITS'(4)) qcount_in = {b, 8'd0};
            else if (offset_ff == LENGTH_BITS'(5)) qcount_in = qcount_ff | {8'd0, b};
            else if (offset_ff == LENGTH_BITS'(6)) acount_in = {b, 8'd0};
            else if (offset_ff == LENGTH_BITS'(7)) acount_in = acount_ff | {8'd0, b};
            if (offset_ff >= LENGTH_BITS'(HDR_LEN - 1)) begin
               if (qcount_ff != 16'd0) phase_in = PH_QNAME;
               else phase_in = (acount_ff != 16'd0) ? PH_ANAME : PH_DONE;
            end
         end
         PH_QNAME, PH_ANAME: begin
            if (skip_ff != 16'd0) skip_in = skip_ff - 16'd1;
            else if ((b & PTR_MASK) == PTR_MASK) begin
               skip_in  = (phase_ff == PH_QNAME) ? 16'(QFIX_LEN) + 16'd1
                                                 : 16'(FIXED_LEN) + 16'd1;
               phase_in = (phase_ff == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
            end else if (b == 8'd0) begin
               skip_in  = (phase_ff == PH_QNAME) ? 16'(QFIX_LEN) : 16'(FIXED_LEN);
               phase_in = (phase_ff == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
            end else skip_in = {8'd0, b};
         end
         PH_QFIXED: begin
            if (skip_ff <= 16'd1) begin
               skip_in   = 16'd0;
               qcount_in = qcount_ff - 16'd1;
               if (qcount_in != 16'd0) phase_in = PH_QNAME;
               else phase_in = (acount_ff != 16'd0) ? PH_ANAME : PH_DONE;
            end else skip_in = skip_ff - 16'd1;
         end
         PH_AFIXED: begin
            if (skip_ff <= 16'(FIXED_LEN)) begin
               if (k == 16'd0) rtype_in = {b, 8'd0};
               else if (k == 16'd1) rtype_in = rtype_ff | {8'd0, b};
               else if (k == 16'd8) rlen_in = {b, 8'd0};
               else if (k == 16'd9) rlen_in = rlen_ff | {8'd0, b};
            end
            if (skip_ff <= 16'd1) begin
               addr_in = '0;
               if (rlen_in == 16'd0) begin
                  skip_in   = 16'd0;
                  acount_in = acount_dec;
                  phase_in  = (acount_dec != 16'd0) ? PH_ANAME : PH_DONE;
               end else begin
                  skip_in  = rlen_in;
                  phase_in = PH_RDATA;
               end
            end else skip_in = skip_ff - 16'd1;
         end
         PH_RDATA: begin
            addr_in = {addr_ff[119:0], b};
            if (skip_ff <= 16'd1) begin
               skip_in = 16'd0;
               if (is_a || is_6) begin
                  out_valid_in         = 1'b1;
                  out_in.is_ipv6       = is_6;
                  out_in.address_high  = is_6 ? addr_in[127:64] : 64'd0;
                  out_in.address_low   = is_6 ? addr_in[63:0] : {32'd0, addr_in[31:0]};
                  out_in.first_a       = is_a && !seen_ff;
                  out_in.result_tag    = tag_in;
                  if (is_a) seen_in = 1'b1;
               end
               acount_in = acount_dec;
               phase_in  = (acount_dec != 16'd0) ? PH_ANAME : PH_DONE;
            end else skip_in = skip_ff - 16'd1;
         end
         default: ;
      endcase

      if (q_item.last) begin
         phase_in  = PH_HEADER;
         offset_in = '0;
         qcount_in = '0;
         acount_in = '0;
         skip_in   = '0;
         rtype_in  = '0;
         rlen_in   = '0;
         addr_in   = '0;
         seen_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         offset_ff    <= '0;
         qcount_ff    <= '0;
         acount_ff    <= '0;
         skip_ff      <= '0;
         rtype_ff     <= '0;
         rlen_ff      <= '0;
         addr_ff      <= '0;
         seen_ff      <= 1'b0;
         tag_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (take) begin
         phase_ff     <= phase_in;
         offset_ff    <= offset_in;
         qcount_ff    <= qcount_in;
         acount_ff    <= acount_in;
         skip_ff      <= skip_in;
         rtype_ff     <= rtype_in;
         rlen_ff      <= rlen_in;
         addr_ff      <= addr_in;
         seen_ff      <= seen_in;
         tag_ff       <= tag_in;
         out_valid_ff <= out_valid_in;
      end else begin
         out_valid_ff <= out_valid_ff && !out_ready;
      end
      if (take) out_ff <= out_in;
   end

   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ready |-> !q_ready) else $error("byte taken while result stalls");
   a_ipv4_high: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.is_ipv6 |-> out_ff.address_high == 64'd0)
      else $error("ipv4 result with high bits");
   a_v6_no_first: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.is_ipv6 |-> !out_ff.first_a) else $error("first_a on ipv6");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      $past(take && q_item.last) |-> phase_ff == PH_HEADER && offset_ff == '0)
      else $error("packet end did not clear parser");

endmodule : dnsx_back
`default_nettype wire

### hdl/dns_answer_address_extractor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dns_answer_address_extractor
// Extracts A and AAAA record addresses from a DNS response byte stream.
// ----------------------------------------------------------------------------
// channel   dir  payload
// req_*     in   tdata: packet_byte[7:0], packet_tag[23:8]; tlast: last_byte
// rsp_*     out  tdata: address_high, address_low, result_tag; tuser: is_ipv6,
//                first_a
//
// One byte per cycle sustained while the receiver takes results; a result passes
// through the queue register and then the parser's output register after the byte
// that completes the record is accepted. A two-entry queue sits between input and
// parser, and the result register stalls the parser only while a result waits.
// Synchronous active-high reset returns the parser to the packet header.
// ----------------------------------------------------------------------------
module dns_answer_address_extractor #(
   parameter int LENGTH_BITS = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [23:0]   req_tdata,   // packet_byte[7:0], packet_tag[23:8]
   input  wire logic          req_tlast,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [143:0]       rsp_tdata,   // address_high[63:0],
                                           // address_low[127:64],
                                           // result_tag[143:128]
   output logic [1:0]         rsp_tuser    // is_ipv6[0], first_a[1]
);
   import dnsx_pkg::*;

   logic          q_valid, q_ready;
   byte_item_type q_item;
   result_type    res;

   dnsx_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_data(req_tdata[7:0]), .in_last(req_tlast), .in_tag(req_tdata[23:8]),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
   );

   dnsx_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_result(res)
   );

   assign rsp_tdata = {res.result_tag, res.address_low, res.address_high};
   assign rsp_tuser = {res.first_a, res.is_ipv6};

endmodule : dns_answer_address_extractor
`default_nettype wire

### tb/dns_answer_address_checker.sv
// ----------------------------------------------------------------------------
// dns_answer_address_checker
// Watches the request and response channels of the DNS answer address
// extractor, predicts each extracted address from the accepted packet bytes
// and compares every response transaction field by field.
// ----------------------------------------------------------------------------
module dns_answer_address_checker (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [23:0]   req_tdata,
   input  logic          req_tlast,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [143:0]  rsp_tdata,
   input  logic [1:0]    rsp_tuser,
   output int            error_count,
   output int            pending_count,
   output int            address_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import dnsx_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER, PH_QNAME, PH_QFIXED, PH_ANAME, PH_AFIXED, PH_RDATA, PH_DONE
   } phase_type;

   localparam logic [15:0] OFFSET_MAX = 16'hFFFF;

   logic [15:0]  offset;
   phase_type    phase;
   logic [15:0]  qd_left;
   logic [15:0]  an_left;
   logic [15:0]  skip_left;
   logic [15:0]  rr_type;
   logic [15:0]  rd_len;
   logic [127:0] addr_shift;
   logic         saw_first_a;
   logic [15:0]  packet_tag_q;

   result_type   expected_addrs[$];

   task automatic clear_parse();
      offset      = '0;
      phase       = PH_HEADER;
      qd_left     = '0;
      an_left     = '0;
      skip_left   = '0;
      rr_type     = '0;
      rd_len      = '0;
      addr_shift  = '0;
      saw_first_a = 1'b0;
   endtask

   task automatic next_record();
      an_left = an_left - 16'd1;
      phase = (an_left != 0) ? PH_ANAME : PH_DONE;
   endtask

   // returns 1 at the end of a name; skip_left then covers the fixed part
   function automatic bit name_step(input logic [7:0] b, input logic [15:0] fixed_len);
      if (skip_left != 0) begin
         skip_left = skip_left - 16'd1;
         return 1'b0;
      end
      if ((b & PTR_MASK) == PTR_MASK) begin
         skip_left = fixed_len + 16'd1;
         return 1'b1;
      end
      if (b == 8'd0) begin
         skip_left = fixed_len;
         return 1'b1;
      end
      skip_left = {8'd0, b};
      return 1'b0;
   endfunction

   task automatic predict_byte(input logic [7:0] b, input logic last, input logic [15:0] tag);
      logic [15:0] pos;
      logic [15:0] k;
      bit          is_v4;
      bit          is_v6;
      result_type  r;
      pos = offset;
      if (pos == 0) packet_tag_q = tag;
      if (offset < OFFSET_MAX) offset = offset + 16'd1;
      case (phase)
         PH_HEADER: begin
            if (pos == 4) qd_left = {b, 8'd0};
            else if (pos == 5) qd_left = qd_left | {8'd0, b};
            else if (pos == 6) an_left = {b, 8'd0};
            else if (pos == 7) an_left = an_left | {8'd0, b};
            if (pos + 1 >= HDR_LEN) begin
               if (qd_left != 0) phase = PH_QNAME;
               else phase = (an_left != 0) ? PH_ANAME : PH_DONE;
            end
         end
         PH_QNAME: begin
            if (name_step(b, 16'(QFIX_LEN))) phase = PH_QFIXED;
         end
         PH_QFIXED: begin
            if (skip_left <= 1) begin
               skip_left = '0;
               qd_left = qd_left - 16'd1;
               if (qd_left != 0) phase = PH_QNAME;
               else phase = (an_left != 0) ? PH_ANAME : PH_DONE;
            end else begin
               skip_left = skip_left - 16'd1;
            end
         end
         PH_ANAME: begin
            if (name_step(b, 16'(FIXED_LEN))) phase = PH_AFIXED;
         end
         PH_AFIXED: begin
            if (skip_left <= 16'(FIXED_LEN)) begin
               k = 16'(FIXED_LEN) - skip_left;
               if (k == 0) rr_type = {b, 8'd0};
               else if (k == 1) rr_type = rr_type | {8'd0, b};
               else if (k == 8) rd_len = {b, 8'd0};
               else if (k == 9) rd_len = rd_len | {8'd0, b};
            end
            if (skip_left <= 1) begin
               addr_shift = '0;
               if (rd_len == 0) begin
                  skip_left = '0;
                  next_record();
               end else begin
                  skip_left = rd_len;
                  phase = PH_RDATA;
               end
            end else begin
               skip_left = skip_left - 16'd1;
            end
         end
         PH_RDATA: begin
            addr_shift = {addr_shift[119:0], b};
            if (skip_left <= 1) begin
               is_v4 = (rr_type == TYPE_A) && (rd_len == LEN_A);
               is_v6 = (rr_type == TYPE_AAAA) && (rd_len == LEN_AAAA);
               skip_left = '0;
               if (is_v4 || is_v6) begin
                  r.is_ipv6      = is_v6;
                  r.address_high = is_v6 ? addr_shift[127:64] : 64'd0;
                  r.address_low  = is_v6 ? addr_shift[63:0] : {32'd0, addr_shift[31:0]};
                  r.first_a      = is_v4 && !saw_first_a;
                  r.result_tag   = packet_tag_q;
                  if (is_v4) saw_first_a = 1'b1;
                  expected_addrs.push_back(r);
               end
               next_record();
            end else begin
               skip_left = skip_left - 16'd1;
            end
         end
         default: ;
      endcase
      if (last) clear_parse();
   endtask

   task automatic report(input string what, input logic [63:0] exp_v, input logic [63:0] act_v);
      error_count++;
      if (error_count <= 10)
         $display("mismatch %s: expected %h actual %h", what, exp_v, act_v);
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         clear_parse();
         packet_tag_q = '0;
         expected_addrs.delete();
         error_count = 0;
         address_count = 0;
      end else begin
         // response first: a result never leaves in the cycle its byte is accepted
         if (rsp_tvalid && rsp_tready) begin
            got.is_ipv6      = rsp_tuser[0];
            got.address_high = rsp_tdata[63:0];
            got.address_low  = rsp_tdata[127:64];
            got.first_a      = rsp_tuser[1];
            got.result_tag   = rsp_tdata[143:128];
            address_count++;
            if (expected_addrs.size() == 0) begin
               report("unexpected transaction", 64'd0, got.address_low);
            end else begin
               want = expected_addrs.pop_front();
               if (got.is_ipv6 != want.is_ipv6)
                  report("is_ipv6", 64'(want.is_ipv6), 64'(got.is_ipv6));
               if (got.address_high != want.address_high)
                  report("address_high", want.address_high, got.address_high);
               if (got.address_low != want.address_low)
                  report("address_low", want.address_low, got.address_low);
               if (got.first_a != want.first_a)
                  report("first_a", 64'(want.first_a), 64'(got.first_a));
               if (got.result_tag != want.result_tag)
                  report("result_tag", 64'(want.result_tag), 64'(got.result_tag));
            end
         end
         if (req_tvalid && req_tready)
            predict_byte(req_tdata[7:0], req_tlast, req_tdata[23:8]);
      end
      pending_count = expected_addrs.size();
   end

   initial begin
      error_count = 0;
      pending_count = 0;
      address_count = 0;
   end

endmodule : dns_answer_address_checker

### tb/dns_answer_address_extractor_test.sv
// ----------------------------------------------------------------------------
// dns_answer_address_extractor_test
// Feeds DNS responses byte by byte into the extractor: directed packets for
// header, name, pointer and truncation cases, then random well-formed
// responses mixed with noise, under bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module dns_answer_address_extractor_test;
   timeunit 1ns;
   timeprecision 1ps;
   import dnsx_pkg::*;

   localparam int ITEM_TARGET = 1550;
   localparam int IDLE_LIMIT  = 5000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [23:0]  req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [143:0] rsp_tdata;
   logic [1:0]   rsp_tuser;

   int error_count;
   int pending_count;
   int address_count;
   int bytes_sent;
   int idle_cycles;
   bit hold_off;
   bit timed_out;

   logic [7:0] pkt[$];

   dns_answer_address_extractor u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   dns_answer_address_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .error_count   (error_count),
      .pending_count (pending_count),
      .address_count (address_count)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver: random stall pattern, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 7) < 5);
   end

   initial begin
      hold_off = 1'b0;
      wait (bytes_sent > 300);
      hold_off = 1'b1;
      repeat (400) @(posedge clock);
      hold_off = 1'b0;
   end

   // watchdog on accepted transactions
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("TB_ERROR");
         $finish;
      end
   end

   // burst sender; valid stays high across back-to-back bytes and packets
   int burst_left = 0;
   task automatic send_packet(input logic [15:0] tag);
      int i;
      for (i = 0; i < pkt.size(); i++) begin
         if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
            burst_left = $urandom_range(1, 40);
         end
         burst_left--;
         req_tvalid <= 1'b1;
         req_tdata  <= {tag, pkt[i]};
         req_tlast  <= (i == pkt.size() - 1);
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         bytes_sent++;
      end
      pkt.delete();
   endtask

   task automatic put16(input logic [15:0] v);
      pkt.push_back(v[15:8]);
      pkt.push_back(v[7:0]);
   endtask

   task automatic put_header(input logic [15:0] qd, input logic [15:0] an);
      int i;
      for (i = 0; i < 4; i++) pkt.push_back(8'($urandom_range(0, 255)));
      put16(qd);
      put16(an);
      for (i = 0; i < 4; i++) pkt.push_back(8'($urandom_range(0, 255)));
   endtask

   // label, compressed-pointer or root name
   task automatic put_name();
      int labels;
      int j;
      int n;
      labels = $urandom_range(0, 2);
      repeat (labels) begin
         n = $urandom_range(1, 8);
         pkt.push_back(n[7:0]);
         for (j = 0; j < n; j++) pkt.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1)) begin
         pkt.push_back(8'hC0 | 8'($urandom_range(0, 63)));
         pkt.push_back(8'($urandom_range(0, 255)));
      end else begin
         pkt.push_back(8'd0);
      end
   endtask

   task automatic put_record(input logic [15:0] rtype, input logic [15:0] rlen);
      int j;
      put_name();
      put16(rtype);
      for (j = 0; j < 6; j++) pkt.push_back(8'($urandom_range(0, 255)));
      put16(rlen);
      for (j = 0; j < rlen; j++) pkt.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic put_random_record();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) put_record(TYPE_A, LEN_A);
      else if (sel < 7) put_record(TYPE_AAAA, LEN_AAAA);
      else if (sel == 7) put_record(TYPE_A, 16'($urandom_range(0, 6)));
      else if (sel == 8) put_record(TYPE_AAAA, 16'($urandom_range(0, 20)));
      else put_record(16'($urandom), 16'($urandom_range(0, 8)));
   endtask

   task automatic build_response();
      int qd;
      int an;
      int i;
      qd = $urandom_range(0, 2);
      an = $urandom_range(0, 4);
      put_header(qd[15:0], an[15:0]);
      for (i = 0; i < qd; i++) begin
         put_name();
         repeat (4) pkt.push_back(8'($urandom_range(0, 255)));
      end
      for (i = 0; i < an; i++) put_random_record();
      // trailing bytes after the counted records
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 5)) pkt.push_back(8'($urandom_range(0, 255)));
   endtask

   initial begin
      int n;
      int cut;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      bytes_sent = 0;
      idle_cycles = 0;
      timed_out  = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: short packet, then one A behind a pointer name and one AAAA
      repeat (5) pkt.push_back(8'hFF);
      send_packet(16'hFFFF);
      put_header(16'd0, 16'd2);
      pkt.push_back(8'hC0);
      pkt.push_back(8'h0C);
      put16(TYPE_A);
      repeat (6) pkt.push_back(8'h00);
      put16(LEN_A);
      pkt.push_back(8'hFF); pkt.push_back(8'h00);
      pkt.push_back(8'hFF); pkt.push_back(8'h00);
      put_record(TYPE_AAAA, LEN_AAAA);
      send_packet(16'h0000);

      // random responses; some cut short, some pure noise
      while (bytes_sent < ITEM_TARGET) begin
         n = $urandom_range(0, 9);
         if (n == 0) begin
            repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom_range(0, 255)));
         end else begin
            build_response();
            if (n == 1) begin
               cut = $urandom_range(1, pkt.size());
               while (pkt.size() > cut) void'(pkt.pop_back());
            end
         end
         send_packet(16'($urandom));
      end
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule : dns_answer_address_extractor_test

### dns_answer_address_extractor.f
hdl/dnsx_pkg.sv
hdl/dnsx_front.sv
hdl/dnsx_back.sv
hdl/dns_answer_address_extractor.sv
tb/dns_answer_address_checker.sv
tb/dns_answer_address_extractor_test.sv
